### rtl/dsa_pkg.sv
// ----------------------------------------------------------------------------
// dsa_pkg
// Types and constants shared by the deferred slot allocator and its checker.
// ----------------------------------------------------------------------------
package dsa_pkg;

    localparam int MAX_SLOTS_DEF     = 1024;
    localparam int PENDING_DEPTH_DEF = 64;
    localparam int RESET_CAPACITY    = 1024;

    localparam int SLOT_W    = 10;
    localparam int FRAME_W   = 32;
    localparam int REL_W     = FRAME_W + 1;
    localparam int CFG_W     = 11;
    localparam int DEFER_W   = 8;
    localparam int RELCNT_W  = 7;

    localparam logic [DEFER_W-1:0] RESET_DEFERRAL = 8'd3;

    typedef enum logic [1:0] {
        OP_ALLOC      = 2'd0,
        OP_FREE_NOW   = 2'd1,
        OP_FREE_DEFER = 2'd2,
        OP_ADVANCE    = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        STAT_OK       = 3'd0,
        STAT_EMPTY    = 3'd1,
        STAT_RANGE    = 3'd2,
        STAT_NOTALLOC = 3'd3,
        STAT_FULL     = 3'd4
    } t_status;

    typedef enum logic [0:0] {
        CFG_CAPACITY = 1'b0,
        CFG_DEFERRAL = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_ALLOC,
        S_FREE,
        S_RESP,
        S_SCAN_CHK,
        S_SCAN_MAP,
        S_SCAN_END
    } t_state;

    typedef struct packed {
        t_op               op;
        logic [SLOT_W-1:0] slot;
        logic [FRAME_W-1:0] frame;
    } t_req;

    typedef struct packed {
        logic [SLOT_W-1:0]   slot_out;
        t_status             status;
        logic [RELCNT_W-1:0] released_count;
    } t_resp;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [REL_W-1:0]  rel_frame;
    } t_pend;

endpackage

### rtl/deferred_slot_allocator.sv
// ----------------------------------------------------------------------------
// deferred_slot_allocator
// Slot allocator with a free stack, an allocated bitmap and a deferred-free
// queue, each held in a synchronous memory.
//
//   channel   direction  handshake                 payload
//   cfg       in         i_cfg_we                  i_cfg_idx, i_cfg_data
//   request   in         i_in_valid / o_in_stall   i_in_req   (t_req)
//   response  out        o_out_valid / i_out_stall o_out_resp (t_resp)
//
// allocate, free now, free deferred: a stack or bitmap read where needed, then
// the response; advance frame: one queue read per queued entry and one bitmap
// read per due, in-range entry, then the response
// reset and every capacity write start an init pass over capacity entries that
// refills the stack and clears the bitmap; requests are stalled meanwhile
// a stalled response is held in the output register; the next request is
// accepted and waits at its last step until the output register is free
// ----------------------------------------------------------------------------
module deferred_slot_allocator #(
    parameter int MAX_SLOTS     = dsa_pkg::MAX_SLOTS_DEF,
    parameter int PENDING_DEPTH = dsa_pkg::PENDING_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  dsa_pkg::t_cfg_idx           i_cfg_idx,
    input  logic [dsa_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  dsa_pkg::t_req               i_in_req,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output dsa_pkg::t_resp              o_out_resp
);

    localparam int SW  = $clog2(MAX_SLOTS);
    localparam int CW  = $clog2(MAX_SLOTS + 1);
    localparam int PW  = $clog2(PENDING_DEPTH);
    localparam int PCW = $clog2(PENDING_DEPTH + 1);
    localparam int RST_CAP = (dsa_pkg::RESET_CAPACITY > MAX_SLOTS) ?
                             MAX_SLOTS : dsa_pkg::RESET_CAPACITY;

    // memories
    logic [SW-1:0]  r_stack_mem [MAX_SLOTS];
    logic           r_map_mem   [MAX_SLOTS];
    dsa_pkg::t_pend r_pend_mem  [PENDING_DEPTH];
    logic [SW-1:0]  r_stack_rd;
    logic           r_map_rd;
    dsa_pkg::t_pend r_pend_rd;

    logic           stack_we, stack_re;
    logic [SW-1:0]  stack_waddr, stack_wdata, stack_raddr;
    logic           map_we, map_re, map_wdata;
    logic [SW-1:0]  map_waddr, map_raddr;
    logic           pend_we, pend_re;
    logic [PW-1:0]  pend_waddr, pend_raddr;
    dsa_pkg::t_pend pend_wdata;

    // control state
    dsa_pkg::t_state            r_state, n_state;
    logic [CW-1:0]              r_capacity, n_capacity;
    logic [dsa_pkg::DEFER_W-1:0] r_deferral, n_deferral;
    logic [CW-1:0]              r_free_count, n_free_count;
    logic [PCW-1:0]             r_pend_count, n_pend_count;
    logic [dsa_pkg::FRAME_W-1:0] r_frame, n_frame;
    logic [CW-1:0]              r_init_idx, n_init_idx;
    logic [PW-1:0]              r_rd_idx, n_rd_idx;
    logic [PCW-1:0]             r_wr_idx, n_wr_idx;
    logic [PCW-1:0]             r_released, n_released;
    logic                       r_out_valid, n_out_valid;
    dsa_pkg::t_req              r_req, n_req;
    dsa_pkg::t_resp             r_out, n_out;

    logic          in_acc, out_free, in_range, pend_due, pend_in_range, more, cap_wr;
    logic [CW-1:0] fc_dec, init_val, cfg_cap;
    logic [PW-1:0] rd_inc;

    assign o_in_stall  = (r_state != dsa_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_resp  = r_out;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign in_range = 32'(i_in_req.slot) < 32'(r_capacity);
    assign pend_due = r_pend_rd.rel_frame <= {1'b0, r_frame};
    assign pend_in_range = 32'(r_pend_rd.slot) < 32'(r_capacity);
    assign more     = (PCW'(r_rd_idx) + PCW'(1)) < r_pend_count;
    assign rd_inc   = r_rd_idx + PW'(1);
    assign fc_dec   = r_free_count - CW'(1);
    assign init_val = r_capacity - CW'(1) - r_init_idx;
    assign cap_wr   = i_cfg_we && (i_cfg_idx == dsa_pkg::CFG_CAPACITY);

    always_comb begin
        if (i_cfg_data == '0) begin
            cfg_cap = CW'(1);
        end else if (32'(i_cfg_data) > MAX_SLOTS) begin
            cfg_cap = CW'(MAX_SLOTS);
        end else begin
            cfg_cap = CW'(i_cfg_data);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dsa_pkg::S_INIT: begin
                if (r_init_idx == r_capacity - CW'(1)) n_state = dsa_pkg::S_IDLE;
            end
            dsa_pkg::S_IDLE: begin
                if (in_acc) begin
                    unique case (i_in_req.op)
                        dsa_pkg::OP_ALLOC: begin
                            n_state = (r_free_count == '0) ? dsa_pkg::S_RESP
                                                           : dsa_pkg::S_ALLOC;
                        end
                        dsa_pkg::OP_FREE_NOW, dsa_pkg::OP_FREE_DEFER: begin
                            n_state = in_range ? dsa_pkg::S_FREE : dsa_pkg::S_RESP;
                        end
                        dsa_pkg::OP_ADVANCE: begin
                            n_state = (r_pend_count == '0) ? dsa_pkg::S_SCAN_END
                                                           : dsa_pkg::S_SCAN_CHK;
                        end
                    endcase
                end
            end
            dsa_pkg::S_ALLOC, dsa_pkg::S_FREE, dsa_pkg::S_RESP,
            dsa_pkg::S_SCAN_END: begin
                if (out_free) n_state = dsa_pkg::S_IDLE;
            end
            dsa_pkg::S_SCAN_CHK: begin
                if (pend_due && pend_in_range) begin
                    n_state = dsa_pkg::S_SCAN_MAP;
                end else if (!more) begin
                    n_state = dsa_pkg::S_SCAN_END;
                end
            end
            dsa_pkg::S_SCAN_MAP: begin
                n_state = more ? dsa_pkg::S_SCAN_CHK : dsa_pkg::S_SCAN_END;
            end
        endcase
        if (cap_wr) n_state = dsa_pkg::S_INIT;
    end

    // datapath and memory control
    always_comb begin
        stack_we    = 1'b0;
        stack_waddr = r_free_count[SW-1:0];
        stack_wdata = SW'(r_req.slot);
        stack_re    = 1'b0;
        stack_raddr = fc_dec[SW-1:0];
        map_we      = 1'b0;
        map_waddr   = SW'(r_req.slot);
        map_wdata   = 1'b0;
        map_re      = 1'b0;
        map_raddr   = SW'(i_in_req.slot);
        pend_we     = 1'b0;
        pend_waddr  = r_pend_count[PW-1:0];
        pend_wdata  = '{slot: r_req.slot,
                        rel_frame: {1'b0, r_frame} + dsa_pkg::REL_W'(r_deferral)};
        pend_re     = 1'b0;
        pend_raddr  = '0;

        n_capacity   = r_capacity;
        n_deferral   = r_deferral;
        n_free_count = r_free_count;
        n_pend_count = r_pend_count;
        n_frame      = r_frame;
        n_init_idx   = r_init_idx;
        n_rd_idx     = r_rd_idx;
        n_wr_idx     = r_wr_idx;
        n_released   = r_released;
        n_req        = r_req;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out        = r_out;

        unique case (r_state)
            dsa_pkg::S_INIT: begin
                stack_we    = 1'b1;
                stack_waddr = r_init_idx[SW-1:0];
                stack_wdata = init_val[SW-1:0];
                map_we      = 1'b1;
                map_waddr   = r_init_idx[SW-1:0];
                n_init_idx  = r_init_idx + CW'(1);
            end
            dsa_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_req = i_in_req;
                    unique case (i_in_req.op)
                        dsa_pkg::OP_ALLOC: begin
                            stack_re = (r_free_count != '0);
                        end
                        dsa_pkg::OP_FREE_NOW, dsa_pkg::OP_FREE_DEFER: begin
                            map_re = in_range;
                        end
                        dsa_pkg::OP_ADVANCE: begin
                            n_frame    = i_in_req.frame;
                            n_rd_idx   = '0;
                            n_wr_idx   = '0;
                            n_released = '0;
                            pend_re    = 1'b1;
                        end
                    endcase
                end
            end
            dsa_pkg::S_ALLOC: begin
                if (out_free) begin
                    map_we       = 1'b1;
                    map_waddr    = r_stack_rd;
                    map_wdata    = 1'b1;
                    n_free_count = fc_dec;
                    n_out_valid  = 1'b1;
                    n_out        = '{slot_out: dsa_pkg::SLOT_W'(r_stack_rd),
                                     status: dsa_pkg::STAT_OK, released_count: '0};
                end
            end
            dsa_pkg::S_FREE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out = '{slot_out: '0, status: dsa_pkg::STAT_OK, released_count: '0};
                    if (!r_map_rd) begin
                        n_out.status = dsa_pkg::STAT_NOTALLOC;
                    end else if (r_req.op == dsa_pkg::OP_FREE_NOW) begin
                        map_we       = 1'b1;
                        stack_we     = 1'b1;
                        n_free_count = r_free_count + CW'(1);
                    end else if (32'(r_pend_count) >= PENDING_DEPTH) begin
                        n_out.status = dsa_pkg::STAT_FULL;
                    end else begin
                        pend_we      = 1'b1;
                        n_pend_count = r_pend_count + PCW'(1);
                    end
                end
            end
            dsa_pkg::S_RESP: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out = '{slot_out: '0, released_count: '0,
                              status: (r_req.op == dsa_pkg::OP_ALLOC) ?
                                      dsa_pkg::STAT_EMPTY : dsa_pkg::STAT_RANGE};
                end
            end
            dsa_pkg::S_SCAN_CHK: begin
                if (!pend_due) begin
                    pend_we    = 1'b1;
                    pend_waddr = r_wr_idx[PW-1:0];
                    pend_wdata = r_pend_rd;
                    n_wr_idx   = r_wr_idx + PCW'(1);
                end
                if (pend_due && pend_in_range) begin
                    map_re    = 1'b1;
                    map_raddr = SW'(r_pend_rd.slot);
                end else begin
                    n_rd_idx   = rd_inc;
                    pend_re    = more;
                    pend_raddr = rd_inc;
                end
            end
            dsa_pkg::S_SCAN_MAP: begin
                if (r_map_rd) begin
                    map_we       = 1'b1;
                    map_waddr    = SW'(r_pend_rd.slot);
                    stack_we     = 1'b1;
                    stack_wdata  = SW'(r_pend_rd.slot);
                    n_free_count = r_free_count + CW'(1);
                    n_released   = r_released + PCW'(1);
                end
                n_rd_idx   = rd_inc;
                pend_re    = more;
                pend_raddr = rd_inc;
            end
            dsa_pkg::S_SCAN_END: begin
                if (out_free) begin
                    n_pend_count = r_wr_idx;
                    n_out_valid  = 1'b1;
                    n_out        = '{slot_out: '0, status: dsa_pkg::STAT_OK,
                                     released_count: dsa_pkg::RELCNT_W'(r_released)};
                end
            end
        endcase

        if (cap_wr) begin
            n_capacity   = cfg_cap;
            n_free_count = cfg_cap;
            n_init_idx   = '0;
        end
        if (i_cfg_we && (i_cfg_idx == dsa_pkg::CFG_DEFERRAL)) begin
            n_deferral = i_cfg_data[dsa_pkg::DEFER_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= dsa_pkg::S_INIT;
            r_capacity   <= CW'(RST_CAP);
            r_deferral   <= dsa_pkg::RESET_DEFERRAL;
            r_free_count <= CW'(RST_CAP);
            r_pend_count <= '0;
            r_frame      <= '0;
            r_init_idx   <= '0;
            r_rd_idx     <= '0;
            r_wr_idx     <= '0;
            r_released   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_capacity   <= n_capacity;
            r_deferral   <= n_deferral;
            r_free_count <= n_free_count;
            r_pend_count <= n_pend_count;
            r_frame      <= n_frame;
            r_init_idx   <= n_init_idx;
            r_rd_idx     <= n_rd_idx;
            r_wr_idx     <= n_wr_idx;
            r_released   <= n_released;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req <= n_req;
        r_out <= n_out;
    end

    // free stack
    always_ff @(posedge i_clk) begin
        if (stack_we) r_stack_mem[stack_waddr] <= stack_wdata;
        if (stack_re) r_stack_rd <= r_stack_mem[stack_raddr];
    end

    // allocated bitmap
    always_ff @(posedge i_clk) begin
        if (map_we) r_map_mem[map_waddr] <= map_wdata;
        if (map_re) r_map_rd <= r_map_mem[map_raddr];
    end

    // deferred-free queue
    always_ff @(posedge i_clk) begin
        if (pend_we) r_pend_mem[pend_waddr] <= pend_wdata;
        if (pend_re) r_pend_rd <= r_pend_mem[pend_raddr];
    end

endmodule

### rtl/dsa_checker.sv
// ----------------------------------------------------------------------------
// dsa_checker
// Port-level checks for the deferred slot allocator, bound to the top level.
// ----------------------------------------------------------------------------
module dsa_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_cfg_we,
    input dsa_pkg::t_cfg_idx         i_cfg_idx,
    input logic                      i_in_valid,
    input logic                      o_in_stall,
    input logic                      o_out_valid,
    input logic                      i_out_stall,
    input dsa_pkg::t_resp            o_out_resp
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("response dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_resp))
        else $error("response changed while stalled");

    a_reset_init: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall && !o_out_valid)
        else $error("no init pass after reset");

    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("request accepted while previous one in flight");

    a_cap_init: assert property (@(posedge i_clk)
        i_cfg_we && (i_cfg_idx == dsa_pkg::CFG_CAPACITY) |=> o_in_stall)
        else $error("capacity write did not start init pass");

endmodule

bind deferred_slot_allocator dsa_checker u_dsa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cfg_we    (i_cfg_we),
    .i_cfg_idx   (i_cfg_idx),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_resp  (o_out_resp)
);
